/* rtl/tsre_pkg.sv */
// ----------------------------------------------------------------------------
// tsre_pkg
// Shared types and constants of the TCP sender retransmit engine.
// ----------------------------------------------------------------------------
package tsre_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [31:0] seqno;
    logic [10:0] len;
    logic        syn;
    logic        fin;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_RECV = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] RK_NEW    = 2'd0;
  localparam logic [1:0] RK_RETX   = 2'd1;
  localparam logic [1:0] RK_STATUS = 2'd2;

  localparam logic [1:0] CFG_RTO  = 2'd0;
  localparam logic [1:0] CFG_ISN  = 2'd1;
  localparam logic [1:0] CFG_MAXP = 2'd2;

  localparam logic [15:0] RTO_RESET  = 16'd1000;
  localparam logic [10:0] MAXP_RESET = 11'd1000;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

/* rtl/tcp_sender_retransmit_engine_core.sv */
// ----------------------------------------------------------------------------
// tcp_sender_retransmit_engine_core
// TCP sender on segment descriptors: segmentation, ack retirement and
// retransmission timer, run by one sequencer over a queue RAM.
//
//  channel  | handshake                  | payload
//  item     | item_valid / item_stall    | kind .. elapsed_ms
//  result   | result_valid / result_stall| result_kind .. last
//  config   | cfg_we                     | cfg_index, cfg_data
//
// One item at a time: new segments are cut, acked segments retired and a
// retransmission sent by a serial walk over the queue RAM (one read or write
// per step).
// Synchronous reset; no clearing pass, queue entries are read only once written.
// A stalled result holds the sequencer; item_stall is high while busy.
// ----------------------------------------------------------------------------
module tcp_sender_retransmit_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] bytes_available,
  input  logic        stream_closed,
  input  logic        ack_valid,
  input  logic [31:0] ack_number,
  input  logic [15:0] peer_window,
  input  logic        peer_reset,
  input  logic [31:0] elapsed_ms,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  result_kind,
  output logic [31:0] seg_seqno,
  output logic        seg_syn,
  output logic        seg_fin,
  output logic        seg_rst,
  output logic [10:0] seg_length,
  output logic [16:0] in_flight,
  output logic [7:0]  retx_count,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tsre_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_CHECK, S_CUT, S_RST, S_RECV, S_RD, S_RET, S_FIN,
    S_TICK, S_CMP, S_RETX, S_DL, S_STATUS
  } state_t;

  state_t state;

  logic        it_ack_valid, it_reset;
  logic [31:0] it_ack, it_elapsed;
  logic [15:0] it_win;

  logic [15:0] rto;
  logic [10:0] maxp;
  logic [QIDX_W-1:0] q_head;
  logic [QCNT_W-1:0] q_count;
  logic [31:0] next_seqno;
  logic [16:0] flight;
  logic [15:0] window;
  logic [63:0] now, deadline;
  logic [7:0]  retx;
  logic [31:0] buffered;
  logic        syn_sent, fin_sent, closed, error, acked;
  logic [16:0] room;
  logic [10:0] pay;

  logic        slot_free;
  logic [QCNT_W:0]   tsum;
  logic [QIDX_W-1:0] tail, head_inc;
  logic [16:0] limit, pay_calc;
  logic [32:0] buf_sum;
  logic        c_syn, c_fin;
  logic [10:0] c_len;
  logic [31:0] buf_left;
  logic [11:0] c_span;
  seg_t        c_seg, h_seg;
  logic [SEG_W-1:0] rdata;
  logic        ram_we;
  logic [11:0] h_span;
  logic [31:0] h_end;
  logic [63:0] delay, rto_shift;

  assign slot_free = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  assign tsum = (QCNT_W + 1)'(q_head) + (QCNT_W + 1)'(q_count);
  assign tail = (tsum >= (QCNT_W + 1)'(QUEUE_DEPTH)) ?
                QIDX_W'(tsum - (QCNT_W + 1)'(QUEUE_DEPTH)) : QIDX_W'(tsum);
  assign head_inc = (q_head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : q_head + 1'b1;

  assign limit    = (window == 16'd0) ? 17'd1 : {1'b0, window};
  assign c_syn    = !syn_sent;
  assign pay_calc = (limit - flight) - 17'(c_syn);
  assign buf_sum  = {1'b0, buffered} + {17'd0, bytes_available};

  always_comb begin
    c_len = 11'd0;
    if (!fin_sent) begin
      c_len = (buffered < {21'd0, pay}) ? buffered[10:0] : pay;
    end
  end
  assign buf_left = buffered - {21'd0, c_len};
  assign c_fin  = !fin_sent && closed && (buf_left == 32'd0) &&
                  ((17'(c_len) + 17'(c_syn)) < room);
  assign c_span = 12'(c_len) + 12'(c_syn) + 12'(c_fin);
  assign c_seg  = '{seqno: next_seqno, len: c_len, syn: c_syn, fin: c_fin};
  assign ram_we = (state == S_CUT) && (c_span != 12'd0) && slot_free;

  assign h_seg  = seg_t'(rdata);
  assign h_span = 12'(h_seg.len) + 12'(h_seg.syn) + 12'(h_seg.fin);
  assign h_end  = h_seg.seqno + 32'(h_span);

  assign rto_shift = {48'd0, rto} << retx[5:0];
  assign delay     = (retx > 8'd47) ? {64{1'b1}} : rto_shift;

  tsre_ram #(.WIDTH(SEG_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (c_seg),
    .raddr (q_head),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rto          <= RTO_RESET;
      maxp         <= MAXP_RESET;
      q_head       <= '0;
      q_count      <= '0;
      next_seqno   <= 32'd0;
      flight       <= 17'd0;
      window       <= 16'd1;
      now          <= 64'd0;
      deadline     <= 64'd0;
      retx         <= 8'd0;
      buffered     <= 32'd0;
      syn_sent     <= 1'b0;
      fin_sent     <= 1'b0;
      closed       <= 1'b0;
      error        <= 1'b0;
      acked        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            it_ack_valid <= ack_valid;
            it_ack       <= ack_number;
            it_win       <= peer_window;
            it_reset     <= peer_reset;
            it_elapsed   <= elapsed_ms;
            acked        <= 1'b0;
            case (kind)
              KIND_PUSH: begin
                buffered <= buf_sum[32] ? {32{1'b1}} : buf_sum[31:0];
                if (stream_closed) begin
                  closed <= 1'b1;
                end
                state <= S_PUSH;
              end
              KIND_RECV: state <= S_RECV;
              KIND_TICK: state <= S_TICK;
              default:   state <= S_STATUS;
            endcase
          end
        end
        S_PUSH: begin
          if (error) begin
            state <= S_RST;
          end else begin
            if (flight == 17'd0) begin
              deadline <= sat_add64(now, {48'd0, rto});
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (flight < limit && q_count < QCNT_W'(QUEUE_DEPTH)) begin
            room  <= limit - flight;
            pay   <= (pay_calc > {6'd0, maxp}) ? maxp : pay_calc[10:0];
            state <= S_CUT;
          end else begin
            state <= S_STATUS;
          end
        end
        S_CUT: begin
          if (c_span == 12'd0) begin
            state <= S_STATUS;
          end else if (slot_free) begin
            q_count      <= q_count + 1'b1;
            flight       <= flight + 17'(c_span);
            next_seqno   <= next_seqno + 32'(c_span);
            buffered     <= buf_left;
            syn_sent     <= 1'b1;
            if (c_fin) begin
              fin_sent <= 1'b1;
            end
            result_valid <= 1'b1;
            result_kind  <= RK_NEW;
            seg_seqno    <= next_seqno;
            seg_syn      <= c_syn;
            seg_fin      <= c_fin;
            seg_rst      <= 1'b0;
            seg_length   <= c_len;
            in_flight    <= 17'd0;
            retx_count   <= 8'd0;
            last         <= 1'b0;
            state        <= S_CHECK;
          end
        end
        S_RST: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            result_kind  <= RK_NEW;
            seg_seqno    <= next_seqno;
            seg_syn      <= 1'b0;
            seg_fin      <= 1'b0;
            seg_rst      <= 1'b1;
            seg_length   <= 11'd0;
            in_flight    <= 17'd0;
            retx_count   <= 8'd0;
            last         <= 1'b0;
            state        <= S_STATUS;
          end
        end
        S_RECV: begin
          if (it_reset) begin
            error <= 1'b1;
            state <= S_STATUS;
          end else if (!it_ack_valid) begin
            window <= it_win;
            state  <= S_STATUS;
          end else if (it_ack > next_seqno) begin
            state <= S_STATUS;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= (q_count == '0) ? S_FIN : S_RET;
        end
        S_RET: begin
          if (h_end > it_ack) begin
            state <= S_FIN;
          end else begin
            flight  <= (flight >= 17'(h_span)) ? flight - 17'(h_span) : 17'd0;
            q_head  <= head_inc;
            q_count <= q_count - 1'b1;
            acked   <= 1'b1;
            state   <= S_RD;
          end
        end
        S_FIN: begin
          if (acked) begin
            retx     <= 8'd0;
            deadline <= sat_add64(now, {48'd0, rto});
          end
          window <= it_win;
          state  <= S_STATUS;
        end
        S_TICK: begin
          if (error) begin
            state <= S_STATUS;
          end else begin
            now   <= now + {32'd0, it_elapsed};
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= (now >= deadline && q_count != '0) ? S_RETX : S_STATUS;
        end
        S_RETX: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            result_kind  <= RK_RETX;
            seg_seqno    <= h_seg.seqno;
            seg_syn      <= h_seg.syn;
            seg_fin      <= h_seg.fin;
            seg_rst      <= 1'b0;
            seg_length   <= h_seg.len;
            in_flight    <= 17'd0;
            retx_count   <= 8'd0;
            last         <= 1'b0;
            if (window != 16'd0 && retx != 8'hFF) begin
              retx <= retx + 1'b1;
            end
            state <= S_DL;
          end
        end
        S_DL: begin
          deadline <= sat_add64(now, delay);
          state    <= S_STATUS;
        end
        S_STATUS: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            result_kind  <= RK_STATUS;
            seg_seqno    <= 32'd0;
            seg_syn      <= 1'b0;
            seg_fin      <= 1'b0;
            seg_rst      <= 1'b0;
            seg_length   <= 11'd0;
            in_flight    <= flight;
            retx_count   <= retx;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          CFG_RTO:  rto  <= cfg_data[15:0];
          CFG_ISN: begin
            if (!syn_sent) begin
              next_seqno <= cfg_data;
            end
          end
          CFG_MAXP: maxp <= cfg_data[10:0];
          default: ;
        endcase
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_last_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> result_kind == RK_STATUS)
    else $error("last on a segment result");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("ready right after accepting an item");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> result_valid && result_kind == RK_NEW)
    else $error("queue write without a new segment result");

endmodule

/* rtl/tsre_ram.sv */
// ----------------------------------------------------------------------------
// tsre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
